// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the record ring queue.
// Depends on nothing; define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("record ring queue: property violated");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_PROP(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- hw/rtl/vrrq_pkg.sv -----
// Types and constants of the variable record ring queue.
// Used by the front decoder, the command queue, the back end and the top level.
package vrrq_pkg;

	localparam int CMD_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 10;
	localparam int LEN_W     = 7;
	localparam int HDR_BYTES = 2;
	localparam int Q_DEPTH   = 2;
	localparam int Q_AW      = $clog2(Q_DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WRAP,
		BK_LEN,
		BK_STREAM
	} back_state_t;

	typedef struct packed {
		cmd_t              op;
		logic [BYTE_W-1:0] data;
		logic              too_long;
		logic [LEN_W-1:0]  total;
	} item_t;

endpackage

// ----- hw/rtl/vrrq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vrrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/vrrq_front.sv -----
// Front decoder: classifies a command and pre-checks the length byte.
// Depends on vrrq_pkg.
module vrrq_front #(
	parameter int MAX_PAYLOAD = 62
) (
	input  logic [vrrq_pkg::CMD_W-1:0]  command,
	input  logic [vrrq_pkg::BYTE_W-1:0] data_byte,
	output vrrq_pkg::item_t             item
);
	import vrrq_pkg::*;

	always_comb begin
		item.op       = cmd_t'(command);
		item.data     = data_byte;
		item.too_long = data_byte > BYTE_W'(MAX_PAYLOAD);
		item.total    = LEN_W'(data_byte) + LEN_W'(HDR_BYTES);
	end

endmodule

// ----- hw/rtl/vrrq_queue.sv -----
// Short command queue between the front decoder and the back end.
// Depends on vrrq_pkg.
module vrrq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vrrq_pkg::item_t din,
	input  logic            pop,
	output vrrq_pkg::item_t dout,
	output logic            full,
	output logic            empty
);
	import vrrq_pkg::*;

	item_t             ent_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q;
	logic [Q_AW-1:0]   rd_q;
	logic [Q_AW:0]     cnt_q;

	assign full  = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule

// ----- hw/rtl/vrrq_back.sv -----
// Back end: executes push, pop, peek and clear against the byte ring.
// Depends on vrrq_pkg and vrrq_ram.
module vrrq_back #(
	parameter int RING_BYTES  = 1024,
	parameter int MAX_PAYLOAD = 62
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vrrq_pkg::item_t               item,
	input  logic                          item_valid,
	output logic                          item_take,
	output logic                          strobe,
	output vrrq_pkg::status_t             status,
	output logic [vrrq_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last,
	output logic [vrrq_pkg::COUNT_W-1:0]  record_count
);
	import vrrq_pkg::*;

	localparam int AW = $clog2(RING_BYTES);
	localparam logic [AW:0]   RING_END = (AW+1)'(RING_BYTES);
	localparam logic [AW-1:0] RING_TOP = AW'(RING_BYTES - 1);

	back_state_t       state_q, state_d;
	logic [AW-1:0]     head_q, head_d, tail_q, tail_d, wp_q, wp_d, ptr_q, ptr_d;
	logic [AW-1:0]     cnt_q, cnt_d;
	logic [LEN_W-1:0]  rem_q, rem_d, idx_q, idx_d, total_q, total_d;
	logic              drop_q, drop_d, pop_q, pop_d;
	logic [BYTE_W-1:0] wbyte_q;
	logic              strobe_d, last_d;
	status_t           status_d;
	logic [BYTE_W-1:0] byte_d;

	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	logic [BYTE_W-1:0] wdata, rdata;

	logic [AW:0]       tail_ext, head_ext, end_ext, base_end;
	logic              wrap, fits;
	logic [AW-1:0]     wp_inc, tail_inc, base;
	logic [BYTE_W-1:0] len;
	logic [LEN_W-1:0]  rec_total;

	vrrq_ram #(.WIDTH(BYTE_W), .DEPTH(RING_BYTES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign item_take    = (state_q == BK_IDLE) && item_valid;
	assign record_count = COUNT_W'(cnt_q);

	always_comb begin
		tail_ext = {1'b0, tail_q};
		head_ext = {1'b0, head_q};
		end_ext  = tail_ext + (AW+1)'(item.total);
		wrap     = end_ext > RING_END;
		if (cnt_q == '0) begin
			fits = 1'b1;
		end else if (!wrap) begin
			fits = (tail_q > head_q) || ((tail_q < head_q) && (end_ext <= head_ext));
		end else begin
			fits = (tail_q > head_q) && ((AW+1)'(item.total) <= head_ext);
		end
		wp_inc   = (wp_q == RING_TOP) ? '0 : wp_q + 1'b1;
		tail_inc = (tail_q == RING_TOP) ? '0 : tail_q + 1'b1;

		len       = (rdata > BYTE_W'(MAX_PAYLOAD)) ? BYTE_W'(MAX_PAYLOAD) : rdata;
		rec_total = LEN_W'(len) + LEN_W'(HDR_BYTES);
		base      = ((head_ext + (AW+1)'(rec_total)) > RING_END) ? '0 : head_q;
		base_end  = {1'b0, base} + (AW+1)'(rec_total);
	end

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		wp_d     = wp_q;
		ptr_d    = ptr_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		idx_d    = idx_q;
		total_d  = total_q;
		drop_d   = drop_q;
		pop_d    = pop_q;
		strobe_d = 1'b0;
		last_d   = 1'b1;
		status_d = ST_OK;
		byte_d   = '0;
		we       = 1'b0;
		waddr    = tail_q;
		wdata    = item.data;
		re       = 1'b0;
		raddr    = head_q;

		case (state_q)
			BK_IDLE: begin
				if (item_valid) begin
					strobe_d = 1'b1;
					case (item.op)
						CMD_PUSH: begin
							if (rem_q == '0) begin
								if (item.too_long) begin
									status_d = ST_TOO_LONG;
								end else begin
									rem_d = item.total - 1'b1;
									if (!fits) begin
										drop_d   = 1'b1;
										status_d = ST_FULL;
									end else begin
										drop_d = 1'b0;
										we     = 1'b1;
										if (wrap) begin
											state_d = BK_WRAP;
										end else begin
											wp_d = tail_inc;
										end
									end
								end
							end else begin
								rem_d = rem_q - 1'b1;
								if (drop_q) begin
									if (rem_q == LEN_W'(1)) begin
										drop_d = 1'b0;
									end
									status_d = ST_FULL;
								end else begin
									we    = 1'b1;
									waddr = wp_q;
									wp_d  = wp_inc;
									if (rem_q == LEN_W'(1)) begin
										tail_d = wp_inc;
										cnt_d  = cnt_q + 1'b1;
									end
								end
							end
						end
						CMD_CLEAR: begin
							head_d = '0;
							tail_d = '0;
							wp_d   = '0;
							cnt_d  = '0;
							rem_d  = '0;
							drop_d = 1'b0;
						end
						default: begin
							if (cnt_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								strobe_d = 1'b0;
								re       = 1'b1;
								pop_d    = item.op == CMD_POP;
								state_d  = BK_LEN;
							end
						end
					endcase
				end
			end
			BK_WRAP: begin
				we      = 1'b1;
				waddr   = '0;
				wdata   = wbyte_q;
				wp_d    = AW'(1);
				state_d = BK_IDLE;
			end
			BK_LEN: begin
				re      = 1'b1;
				raddr   = base;
				ptr_d   = base + 1'b1;
				idx_d   = '0;
				total_d = rec_total;
				if (pop_q) begin
					head_d = (base_end == RING_END) ? '0 : AW'(base_end);
					cnt_d  = cnt_q - 1'b1;
				end
				state_d = BK_STREAM;
			end
			BK_STREAM: begin
				strobe_d = 1'b1;
				byte_d   = rdata;
				last_d   = idx_q == total_q - 1'b1;
				if (last_d) begin
					state_d = BK_IDLE;
				end else begin
					re    = 1'b1;
					raddr = ptr_q;
					ptr_d = ptr_q + 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			drop_q  <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			wp_q    <= wp_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			drop_q  <= drop_d;
			strobe  <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		idx_q    <= idx_d;
		total_q  <= total_d;
		pop_q    <= pop_d;
		wbyte_q  <= item.data;
		status   <= status_d;
		out_byte <= byte_d;
		last     <= last_d;
	end

endmodule

// ----- hw/rtl/variable_record_ring_queue.sv -----
// Variable-length record ring queue: front decoder, two-entry command queue, back end.
// Push, clear, empty pop/peek: one registered result; a wrapping push passes BK_WRAP.
// Pop/peek: L+2 results on consecutive cycles, after the back end passes BK_LEN.
// Busy rises only while the command queue is full; results cannot be stalled.
// Reset clears head/tail/write pointers, counts, queue; ring bytes undefined until written.
// Depends on vrrq_pkg, vrrq_front, vrrq_queue, vrrq_back, vrrq_ram, assert_macros.svh.
`include "assert_macros.svh"

module variable_record_ring_queue #(
	parameter int RING_BYTES  = 1024,
	parameter int MAX_PAYLOAD = 62
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [vrrq_pkg::CMD_W-1:0]    command,
	input  logic [vrrq_pkg::BYTE_W-1:0]   data_byte,
	output logic                          strobe,
	output logic [vrrq_pkg::STATUS_W-1:0] status,
	output logic [vrrq_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last,
	output logic [vrrq_pkg::COUNT_W-1:0]  record_count
);
	import vrrq_pkg::*;

	item_t   in_item, q_item;
	logic    q_full, q_empty, q_take, accept;
	status_t bk_status;

	assign accept = start && !busy;
	assign busy   = q_full;
	assign status = bk_status;

	vrrq_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.command   (command),
		.data_byte (data_byte),
		.item      (in_item)
	);

	vrrq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (in_item),
		.pop    (q_take),
		.dout   (q_item),
		.full   (q_full),
		.empty  (q_empty)
	);

	vrrq_back #(.RING_BYTES(RING_BYTES), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (q_item),
		.item_valid   (!q_empty),
		.item_take    (q_take),
		.strobe       (strobe),
		.status       (bk_status),
		.out_byte     (out_byte),
		.last         (last),
		.record_count (record_count)
	);

	`ASSERT_PROP(a_busy_after_accept, clk, arst_n, $rose(busy) |-> $past(accept))
	`ASSERT_PROP(a_empty_answer, clk, arst_n, (strobe && bk_status == ST_EMPTY) |-> (last && record_count == '0))
	`ASSERT_PROP(a_error_no_byte, clk, arst_n, (strobe && bk_status != ST_OK) |-> (out_byte == '0 && last))
	`ASSERT_PROP(a_take_needs_item, clk, arst_n, q_take |-> !q_empty)

endmodule
